@@ rtl/qpht_pkg.sv @@
// shared types and constants for the quadratic probe hash table
// no dependencies; used by every module in rtl
package qpht_pkg;

    localparam int MAX_SLOTS  = 1024;
    localparam int KEY_BITS   = 32;
    localparam int MIN_SIZE   = 5;
    localparam int RESET_SIZE = 11;

    localparam int SLOT_W = $clog2(MAX_SLOTS);
    localparam int SIZE_W = $clog2(MAX_SLOTS + 1);
    localparam int CNT_W  = $clog2(KEY_BITS);

    // stream word widths, packed fields rounded up to whole bytes
    localparam int IN_FIELDS_W  = KEY_BITS + SLOT_W;
    localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = SLOT_W + KEY_BITS + 1 + 2;
    localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

    typedef enum logic [1:0] {
        KIND_FIND     = 2'd0,
        KIND_INSERT   = 2'd1,
        KIND_RETRIEVE = 2'd2,
        KIND_CLEAR    = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        STAT_OK     = 2'd0,
        STAT_ABSENT = 2'd1,
        STAT_LIMIT  = 2'd2
    } status_t;

    // one slot of the table store
    typedef struct packed {
        logic                used;
        logic [KEY_BITS-1:0] key;
    } slot_t;

    // slot store write request
    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] addr;
        slot_t             data;
    } slot_wr_t;

endpackage

@@ rtl/qpht_mod.sv @@
// iterative key modulo table size, one dividend bit per cycle
// depends on qpht_pkg
module qpht_mod (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [qpht_pkg::KEY_BITS-1:0] dividend,
    input  logic [qpht_pkg::SIZE_W-1:0]   divisor,
    output logic                          done,
    output logic [qpht_pkg::SIZE_W-1:0]   remainder
);

    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [qpht_pkg::CNT_W-1:0]    cnt_reg, cnt_next;
    logic [qpht_pkg::KEY_BITS-1:0] shift_reg, shift_next;
    logic [qpht_pkg::SIZE_W-1:0]   rem_reg, rem_next;
    logic [qpht_pkg::SIZE_W:0]     trial;

    // shift in the next dividend bit and subtract once if it fits
    assign trial = {rem_reg, shift_reg[qpht_pkg::KEY_BITS-1]};

    always_comb begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        cnt_next   = cnt_reg;
        shift_next = shift_reg;
        rem_next   = rem_reg;
        if (start) begin
            busy_next  = 1'b1;
            cnt_next   = '0;
            shift_next = dividend;
            rem_next   = '0;
        end else if (busy_reg) begin
            shift_next = {shift_reg[qpht_pkg::KEY_BITS-2:0], 1'b0};
            if (trial >= {1'b0, divisor}) begin
                rem_next = qpht_pkg::SIZE_W'(trial - {1'b0, divisor});
            end else begin
                rem_next = trial[qpht_pkg::SIZE_W-1:0];
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == qpht_pkg::CNT_W'(qpht_pkg::KEY_BITS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        shift_reg <= shift_next;
        rem_reg   <= rem_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

@@ rtl/qpht_ram.sv @@
// slot store: key and occupied mark per slot, one write and one read port
// depends on qpht_pkg
module qpht_ram (
    input  logic                        aclk,
    input  qpht_pkg::slot_wr_t          wr,
    input  logic [qpht_pkg::SLOT_W-1:0] rd_addr,
    output qpht_pkg::slot_t             rd_data
);

    qpht_pkg::slot_t mem [qpht_pkg::MAX_SLOTS];
    qpht_pkg::slot_t rd_data_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/quadratic_probe_hash_table.sv @@
// quadratic probe hash table: find, insert, retrieve and clear over a slot store
// sequence: find/insert run the modulo unit, then a store read and a check per probe, and one more
//   on the probe limit; retrieve does one read and check (none out of range); clear sweeps every slot
// throughput: one word at a time, next word taken the cycle after the result is staged
// reset: synchronous, active low; a sweep of every slot empties the store before any word
// depends on qpht_pkg, qpht_mod, qpht_ram
module quadratic_probe_hash_table (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration: table_size
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [qpht_pkg::SIZE_W-1:0]       cfg_data,
    // input words
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [qpht_pkg::IN_DATA_W-1:0]    s_tdata,  // key, slot_index, zero pad
    input  logic [1:0]                        s_tuser,  // kind
    // result words
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [qpht_pkg::OUT_DATA_W-1:0]   m_tdata   // position, stored_key,
                                                        // occupied, status, zero pad
);

    typedef enum logic [2:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_HASH,
        ST_ISSUE,
        ST_CHECK,
        ST_RESP
    } state_t;

    state_t                        state_reg, state_next;
    logic [qpht_pkg::SIZE_W-1:0]   size_reg, size_next;
    logic [qpht_pkg::SIZE_W-1:0]   ts;
    qpht_pkg::kind_t               kind_reg, kind_next;
    logic [qpht_pkg::KEY_BITS-1:0] key_reg, key_next;
    logic [qpht_pkg::SLOT_W-1:0]   addr_reg, addr_next;
    logic [qpht_pkg::SLOT_W-1:0]   home_reg, home_next;
    logic [qpht_pkg::SIZE_W-1:0]   step_reg, step_next;
    logic [qpht_pkg::SIZE_W-1:0]   probe_reg, probe_next;
    logic                          limit_reg, limit_next;
    logic [qpht_pkg::SLOT_W-1:0]   sweep_reg, sweep_next;
    logic                          clr_resp_reg, clr_resp_next;
    logic [qpht_pkg::SLOT_W-1:0]   res_pos_reg, res_pos_next;
    logic [qpht_pkg::KEY_BITS-1:0] res_key_reg, res_key_next;
    logic                          res_occ_reg, res_occ_next;
    qpht_pkg::status_t             res_stat_reg, res_stat_next;
    logic                          m_tvalid_reg, m_tvalid_next;
    logic [qpht_pkg::OUT_DATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic                          mod_start;
    logic                          mod_done;
    logic [qpht_pkg::SIZE_W-1:0]   mod_rem;
    qpht_pkg::slot_wr_t            wr;
    qpht_pkg::slot_t               rd_data;
    logic [qpht_pkg::SIZE_W:0]     pos_sum;
    logic [qpht_pkg::SIZE_W:0]     step_sum;
    logic [qpht_pkg::SIZE_W-1:0]   pos_adv;
    logic [qpht_pkg::SIZE_W-1:0]   step_adv;
    logic                          s_fire;
    logic                          out_free;
    logic [qpht_pkg::SLOT_W-1:0]   in_idx;

    // table size in use, clamped to the supported range
    always_comb begin
        ts = size_reg;
        if (size_reg < qpht_pkg::SIZE_W'(qpht_pkg::MIN_SIZE)) begin
            ts = qpht_pkg::SIZE_W'(qpht_pkg::MIN_SIZE);
        end else if (size_reg > qpht_pkg::SIZE_W'(qpht_pkg::MAX_SLOTS)) begin
            ts = qpht_pkg::SIZE_W'(qpht_pkg::MAX_SLOTS);
        end
    end

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign s_fire    = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign in_idx    = s_tdata[qpht_pkg::KEY_BITS +: qpht_pkg::SLOT_W];

    // next probe slot and the step grown by two, each kept below the table size
    assign pos_sum  = {1'b0, qpht_pkg::SIZE_W'(addr_reg)} + {1'b0, step_reg};
    assign pos_adv  = (pos_sum >= {1'b0, ts}) ? qpht_pkg::SIZE_W'(pos_sum - {1'b0, ts})
                                               : pos_sum[qpht_pkg::SIZE_W-1:0];
    assign step_sum = {1'b0, step_reg} + (qpht_pkg::SIZE_W + 1)'(2);
    assign step_adv = (step_sum >= {1'b0, ts}) ? qpht_pkg::SIZE_W'(step_sum - {1'b0, ts})
                                                : step_sum[qpht_pkg::SIZE_W-1:0];

    assign mod_start = s_fire && (s_tuser == qpht_pkg::KIND_FIND
                                  || s_tuser == qpht_pkg::KIND_INSERT);

    qpht_mod u_mod (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (mod_start),
        .dividend  (s_tdata[qpht_pkg::KEY_BITS-1:0]),
        .divisor   (ts),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    qpht_ram u_ram (
        .aclk    (aclk),
        .wr      (wr),
        .rd_addr (addr_reg),
        .rd_data (rd_data)
    );

    // sequencer
    always_comb begin
        state_next    = state_reg;
        size_next     = size_reg;
        kind_next     = kind_reg;
        key_next      = key_reg;
        addr_next     = addr_reg;
        home_next     = home_reg;
        step_next     = step_reg;
        probe_next    = probe_reg;
        limit_next    = limit_reg;
        sweep_next    = sweep_reg;
        clr_resp_next = clr_resp_reg;
        res_pos_next  = res_pos_reg;
        res_key_next  = res_key_reg;
        res_occ_next  = res_occ_reg;
        res_stat_next = res_stat_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        wr.en         = 1'b0;
        wr.addr       = addr_reg;
        wr.data.used  = 1'b1;
        wr.data.key   = key_reg;

        if (cfg_valid) begin
            size_next = cfg_data;
        end
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_SWEEP: begin
                wr.en   = 1'b1;
                wr.addr = sweep_reg;
                wr.data = '0;
                sweep_next = sweep_reg + 1'b1;
                if (sweep_reg == qpht_pkg::SLOT_W'(qpht_pkg::MAX_SLOTS - 1)) begin
                    state_next = clr_resp_reg ? ST_RESP : ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_fire) begin
                    kind_next = qpht_pkg::kind_t'(s_tuser);
                    key_next  = s_tdata[qpht_pkg::KEY_BITS-1:0];
                    case (qpht_pkg::kind_t'(s_tuser))
                        qpht_pkg::KIND_FIND, qpht_pkg::KIND_INSERT: begin
                            state_next = ST_HASH;
                        end
                        qpht_pkg::KIND_RETRIEVE: begin
                            addr_next  = in_idx;
                            limit_next = 1'b0;
                            if ({1'b0, in_idx} >= ts) begin
                                res_pos_next  = in_idx;
                                res_key_next  = '0;
                                res_occ_next  = 1'b0;
                                res_stat_next = qpht_pkg::STAT_ABSENT;
                                state_next    = ST_RESP;
                            end else begin
                                state_next = ST_ISSUE;
                            end
                        end
                        default: begin
                            sweep_next    = '0;
                            clr_resp_next = 1'b1;
                            res_pos_next  = '0;
                            res_key_next  = '0;
                            res_occ_next  = 1'b0;
                            res_stat_next = qpht_pkg::STAT_OK;
                            state_next    = ST_SWEEP;
                        end
                    endcase
                end
            end
            ST_HASH: begin
                if (mod_done) begin
                    home_next  = mod_rem[qpht_pkg::SLOT_W-1:0];
                    addr_next  = mod_rem[qpht_pkg::SLOT_W-1:0];
                    step_next  = qpht_pkg::SIZE_W'(1);
                    probe_next = '0;
                    limit_next = 1'b0;
                    state_next = ST_ISSUE;
                end
            end
            ST_ISSUE: begin
                // store read data for addr_reg lands at the end of this cycle
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                res_pos_next = addr_reg;
                res_key_next = rd_data.used ? rd_data.key : '0;
                res_occ_next = rd_data.used;
                if (kind_reg == qpht_pkg::KIND_RETRIEVE) begin
                    res_stat_next = rd_data.used ? qpht_pkg::STAT_OK : qpht_pkg::STAT_ABSENT;
                    state_next    = ST_RESP;
                end else if (limit_reg) begin
                    res_stat_next = qpht_pkg::STAT_LIMIT;
                    state_next    = ST_RESP;
                end else if (!rd_data.used) begin
                    if (kind_reg == qpht_pkg::KIND_INSERT) begin
                        wr.en         = 1'b1;
                        res_key_next  = key_reg;
                        res_occ_next  = 1'b1;
                        res_stat_next = qpht_pkg::STAT_OK;
                    end else begin
                        res_stat_next = qpht_pkg::STAT_ABSENT;
                    end
                    state_next = ST_RESP;
                end else if (rd_data.key == key_reg) begin
                    res_stat_next = qpht_pkg::STAT_OK;
                    state_next    = ST_RESP;
                end else if (probe_reg == ts - 1'b1) begin
                    // path exhausted: report the home slot
                    limit_next = 1'b1;
                    addr_next  = home_reg;
                    state_next = ST_ISSUE;
                end else begin
                    addr_next  = pos_adv[qpht_pkg::SLOT_W-1:0];
                    step_next  = step_adv;
                    probe_next = probe_reg + 1'b1;
                    state_next = ST_ISSUE;
                end
            end
            ST_RESP: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {(qpht_pkg::OUT_DATA_W - qpht_pkg::OUT_FIELDS_W)'(0),
                                     res_stat_reg, res_occ_reg, res_key_reg, res_pos_reg};
                    clr_resp_next = 1'b0;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_SWEEP;
            size_reg     <= qpht_pkg::SIZE_W'(qpht_pkg::RESET_SIZE);
            sweep_reg    <= '0;
            clr_resp_reg <= 1'b0;
            limit_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            size_reg     <= size_next;
            sweep_reg    <= sweep_next;
            clr_resp_reg <= clr_resp_next;
            limit_reg    <= limit_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        kind_reg     <= kind_next;
        key_reg      <= key_next;
        addr_reg     <= addr_next;
        home_reg     <= home_next;
        step_reg     <= step_next;
        probe_reg    <= probe_next;
        res_pos_reg  <= res_pos_next;
        res_key_reg  <= res_key_next;
        res_occ_reg  <= res_occ_next;
        res_stat_reg <= res_stat_next;
        m_tdata_reg  <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef ASSERT_OFF
    // status never goes beyond the probe limit code
    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[qpht_pkg::SLOT_W + qpht_pkg::KEY_BITS + 2 -: 2]
                      <= 2'(qpht_pkg::STAT_LIMIT)))
        else $error("result status code out of range");

    // an empty slot always reports a zero key
    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tdata[qpht_pkg::SLOT_W + qpht_pkg::KEY_BITS])
        |-> (m_tdata[qpht_pkg::SLOT_W +: qpht_pkg::KEY_BITS] == '0))
        else $error("empty slot reported with a nonzero key");

    // one word at a time: no new word straight after an accepted one
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("word accepted while the previous one is in flight");

    // the store is only written while sweeping or checking a probe
    a_write_states: assert property (@(posedge aclk) disable iff (!aresetn)
        wr.en |-> (state_reg == ST_SWEEP || state_reg == ST_CHECK))
        else $error("slot store written outside sweep or probe check");
`endif

endmodule

@@ verif/qpht_checker.sv @@
`timescale 1ns / 100ps
// result checker for the quadratic probe hash table: watches configuration, input and result
// words, keeps a shadow slot table, predicts each result and compares it field by field
// depends on qpht_pkg
module qpht_checker
    import qpht_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [SIZE_W-1:0]     cfg_data,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // key, slot_index, zero pad
    input  logic [1:0]            s_tuser,   // kind
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [OUT_DATA_W-1:0] m_tdata,   // position, stored_key, occupied, status, zero pad
    output int                    fault_count,
    output int                    pending,
    output int                    results_seen,
    output int                    limit_hits
);

    // one result word, unpacked
    typedef struct packed {
        logic [SLOT_W-1:0]   position;
        logic [KEY_BITS-1:0] stored_key;
        logic                occupied;
        status_t             status;
    } lookup_res_t;

    // shadow of the slot store and the size register
    logic [KEY_BITS-1:0] shadow_keys [MAX_SLOTS];
    logic                shadow_used [MAX_SLOTS];
    logic [SIZE_W-1:0]   size_reg;
    lookup_res_t         awaited [$];
    int                  faults;
    int                  checked;
    int                  limits;

    // size actually in use after clamping to the built range
    function automatic int unsigned live_span();
        int unsigned t;
        t = size_reg;
        if (t < MIN_SIZE) t = MIN_SIZE;
        if (t > MAX_SLOTS) t = MAX_SLOTS;
        return t;
    endfunction

    // quadratic walk from the home slot; stops at an empty slot, the key itself, or the probe limit
    function automatic status_t walk_probe(input logic [KEY_BITS-1:0] key,
                                           input int unsigned span,
                                           output int unsigned slot);
        int unsigned home;
        int unsigned cur;
        home = key % span;
        cur  = home;
        for (int unsigned i = 0; i < span; i++) begin
            if (!shadow_used[cur]) begin
                slot = cur;
                return STAT_ABSENT;
            end
            if (shadow_keys[cur] == key) begin
                slot = cur;
                return STAT_OK;
            end
            cur = (cur + 2 * i + 1) % span;
        end
        slot = home;
        return STAT_LIMIT;
    endfunction

    // result word describing one slot
    function automatic lookup_res_t slot_view(input int unsigned slot, input status_t st);
        lookup_res_t r;
        r.position   = SLOT_W'(slot);
        r.occupied   = shadow_used[slot];
        r.stored_key = shadow_used[slot] ? shadow_keys[slot] : '0;
        r.status     = st;
        return r;
    endfunction

    // apply one operation to the shadow table and return its result word
    function automatic lookup_res_t apply_op(input kind_t op, input logic [KEY_BITS-1:0] key,
                                             input logic [SLOT_W-1:0] idx);
        lookup_res_t r;
        int unsigned span;
        int unsigned slot;
        status_t     st;
        span = live_span();
        r    = '0;
        case (op)
            KIND_FIND: begin
                st = walk_probe(key, span, slot);
                r  = slot_view(slot, st);
            end
            KIND_INSERT: begin
                st = walk_probe(key, span, slot);
                if (st == STAT_ABSENT) begin
                    shadow_keys[slot] = key;
                    shadow_used[slot] = 1'b1;
                    st = STAT_OK;
                end
                r = slot_view(slot, st);
            end
            KIND_RETRIEVE: begin
                if (idx >= span) begin
                    r.position = idx;
                    r.status   = STAT_ABSENT;
                end else begin
                    r = slot_view(idx, shadow_used[idx] ? STAT_OK : STAT_ABSENT);
                end
            end
            default: begin
                foreach (shadow_used[j]) shadow_used[j] = 1'b0;
                r.status = STAT_OK;
            end
        endcase
        return r;
    endfunction

    // one line per mismatch, and a running count
    task automatic report_fault(input string what, input logic [63:0] got,
                                input logic [63:0] want);
        $display("[%0t] hash table check, result %0d: %s got %0h want %0h",
                 $time, checked, what, got, want);
        faults++;
    endtask

    // watch the three channels at each edge
    always @(posedge aclk) begin
        lookup_res_t seen;
        lookup_res_t want;
        if (!aresetn) begin
            size_reg = SIZE_W'(RESET_SIZE);
            foreach (shadow_used[j]) shadow_used[j] = 1'b0;
            awaited.delete();
            faults  = 0;
            checked = 0;
            limits  = 0;
        end else begin
            if (cfg_valid && cfg_ready)
                size_reg = cfg_data;

            // result word against the oldest prediction
            if (m_tvalid && m_tready) begin
                seen.position   = m_tdata[SLOT_W-1:0];
                seen.stored_key = m_tdata[SLOT_W +: KEY_BITS];
                seen.occupied   = m_tdata[SLOT_W + KEY_BITS];
                seen.status     = status_t'(m_tdata[SLOT_W + KEY_BITS + 1 +: 2]);
                checked++;
                if (awaited.size() == 0) begin
                    report_fault("result word with nothing outstanding", 64'(m_tdata), '0);
                end else begin
                    want = awaited.pop_front();
                    if (want.status == STAT_LIMIT)
                        limits++;
                    if (seen.position !== want.position)
                        report_fault("position", 64'(seen.position), 64'(want.position));
                    if (seen.stored_key !== want.stored_key)
                        report_fault("stored_key", 64'(seen.stored_key), 64'(want.stored_key));
                    if (seen.occupied !== want.occupied)
                        report_fault("occupied", 64'(seen.occupied), 64'(want.occupied));
                    if (seen.status !== want.status)
                        report_fault("status", 64'(seen.status), 64'(want.status));
                end
            end

            // input word: predict its result now, in arrival order
            if (s_tvalid && s_tready)
                awaited.push_back(apply_op(kind_t'(s_tuser), s_tdata[KEY_BITS-1:0],
                                           s_tdata[KEY_BITS +: SLOT_W]));
        end
        pending      <= awaited.size();
        results_seen <= checked;
        fault_count  <= faults;
        limit_hits   <= limits;
    end

endmodule

@@ verif/tb_quadratic_probe_hash_table.sv @@
`timescale 1ns / 100ps
// top of the hash table testbench: clock, reset, stimulus, result back-pressure and verdict
// depends on qpht_pkg, quadratic_probe_hash_table and qpht_checker
module tb_quadratic_probe_hash_table;
    import qpht_pkg::*;

    localparam int WATCHDOG    = 20000;
    localparam int HOLD_CYCLES = 300;
    localparam int HOLD_AFTER  = 150;
    localparam int PHASES      = 8;
    localparam int PER_PHASE   = 50;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [SIZE_W-1:0]     cfg_data  = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;
    logic [1:0]            s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;

    int fault_count;
    int pending;
    int results_seen;
    int limit_hits;

    bit          calm       = 1'b0;
    int unsigned span       = RESET_SIZE;
    int          sent_by_kind [4];
    int          size_writes = 0;
    int          stall_left  = 0;
    bit          stall_done  = 1'b0;
    int          idle_run    = 0;

    quadratic_probe_hash_table dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    qpht_checker u_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .fault_count  (fault_count),
        .pending      (pending),
        .results_seen (results_seen),
        .limit_hits   (limit_hits)
    );

    // 12 ns clock
    always #6 aclk = ~aclk;

    // result side: random stalls, one long hold-off once the run is under way
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready   <= 1'b0;
            stall_left <= 0;
            stall_done <= 1'b0;
        end else if (stall_left != 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (!stall_done && results_seen >= HOLD_AFTER) begin
            m_tready   <= 1'b0;
            stall_left <= HOLD_CYCLES;
            stall_done <= 1'b1;
        end else begin
            m_tready <= calm || ($urandom_range(99) >= 10);
        end
    end

    // watchdog on cycles with no word moving on any channel
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready)) begin
            idle_run <= 0;
        end else if (idle_run >= WATCHDOG) begin
            $display("[%0t] no word moved for %0d cycles", $time, WATCHDOG);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            idle_run <= idle_run + 1;
        end
    end

    // table size after clamping, used only to shape keys and slot indexes
    function automatic int unsigned clamp_span(input int unsigned v);
        if (v < MIN_SIZE) return MIN_SIZE;
        if (v > MAX_SLOTS) return MAX_SLOTS;
        return v;
    endfunction

    // offer one word and hold it until taken, then, unless calm, randomly drop valid for a while
    task automatic send_word(input kind_t op, input logic [KEY_BITS-1:0] key,
                             input logic [SLOT_W-1:0] idx);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= IN_DATA_W'({idx, key});
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sent_by_kind[op]++;
        if (!calm) begin
            while ($urandom_range(99) < 10) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
            end
        end
    endtask

    // stop offering and wait until every predicted result has arrived
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    // table size write, only ever issued with the block idle
    task automatic write_size(input int unsigned sz);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= SIZE_W'(sz);
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        span = clamp_span(sz & ((1 << SIZE_W) - 1));
        size_writes++;
    endtask

    initial begin
        int unsigned         phase_size [PHASES];
        logic [KEY_BITS-1:0] key_pool [$];
        logic [KEY_BITS-1:0] key;
        logic [SLOT_W-1:0]   idx;
        kind_t               op;
        int unsigned         roll;

        phase_size = '{7, 13, 3, 5, 31, 1021, 17, 1024};
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: collisions, present and absent keys, retrieve bounds at reset size 11
        send_word(KIND_FIND, 32'd0, '0);
        send_word(KIND_INSERT, 32'd0, '0);
        send_word(KIND_INSERT, 32'd11, '0);
        send_word(KIND_INSERT, 32'd22, '0);
        send_word(KIND_INSERT, 32'd10, '0);
        send_word(KIND_INSERT, 32'hFFFF_FFFF, '0);
        send_word(KIND_FIND, 32'd11, '0);
        send_word(KIND_INSERT, 32'd11, '0);
        send_word(KIND_FIND, 32'd33, '0);
        send_word(KIND_RETRIEVE, '0, 10'd0);
        send_word(KIND_RETRIEVE, '0, 10'd10);
        send_word(KIND_RETRIEVE, '0, 10'd11);
        send_word(KIND_RETRIEVE, 32'hFFFF_FFFF, 10'd1023);

        // shrink to 5: home 0 path is full, so insert and find hit the probe limit
        write_size(5);
        send_word(KIND_INSERT, 32'd5, '0);
        send_word(KIND_FIND, 32'd5, '0);
        send_word(KIND_RETRIEVE, '0, 10'd10);

        // grow back: slot 10 still holds its old key
        write_size(11);
        send_word(KIND_RETRIEVE, '0, 10'd10);
        send_word(KIND_CLEAR, 32'hFFFF_FFFF, 10'd1023);
        send_word(KIND_RETRIEVE, '0, 10'd0);

        // size below the minimum and above the built capacity
        write_size(0);
        send_word(KIND_INSERT, 32'd7, '0);
        send_word(KIND_RETRIEVE, '0, 10'd4);
        write_size(2047);
        send_word(KIND_INSERT, 32'hFFFF_FFFF, '0);
        send_word(KIND_RETRIEVE, '0, 10'd1023);
        send_word(KIND_FIND, 32'h8000_0000, '0);
        send_word(KIND_CLEAR, '0, '0);

        // random phases, one table size each; small tables fill up and hit the limit
        for (int ph = 0; ph < PHASES; ph++) begin
            write_size(phase_size[ph]);
            calm <= (ph == 4);
            for (int n = 0; n < PER_PHASE; n++) begin
                if (ph == 1 && n == 25)
                    wait_drained();
                roll = $urandom_range(99);
                if (roll < 4)       op = KIND_CLEAR;
                else if (roll < 45) op = KIND_INSERT;
                else if (roll < 75) op = KIND_FIND;
                else if (roll < 90) op = KIND_RETRIEVE;
                else                op = kind_t'($urandom_range(3));
                // keys: fully random, reused, or small multiples of the span plus a random home
                roll = $urandom_range(99);
                if (roll < 25)
                    key = $urandom();
                else if (roll < 60 && key_pool.size() != 0)
                    key = key_pool[$urandom_range(key_pool.size() - 1)];
                else
                    key = KEY_BITS'($urandom_range(9) * span + $urandom_range(span - 1));
                if ($urandom_range(4) == 0)
                    idx = SLOT_W'($urandom_range(MAX_SLOTS - 1));
                else
                    idx = SLOT_W'($urandom_range(span - 1));
                send_word(op, key, idx);
                if (op == KIND_INSERT) begin
                    key_pool.push_back(key);
                    if (key_pool.size() > 64)
                        void'(key_pool.pop_front());
                end else if (op == KIND_CLEAR) begin
                    key_pool.delete();
                end
            end
        end
        calm <= 1'b0;

        wait_drained();
        repeat (60) @(posedge aclk);

        $display("run covered %0d finds, %0d inserts, %0d retrieves and %0d clears",
                 sent_by_kind[KIND_FIND], sent_by_kind[KIND_INSERT],
                 sent_by_kind[KIND_RETRIEVE], sent_by_kind[KIND_CLEAR]);
        $display("over %0d size writes; %0d result words compared, %0d at the probe limit",
                 size_writes, results_seen, limit_hits);
        if (fault_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
